>>> design/oldest_first_paired_fork_arbiter_assert.svh
// ----------------------------------------------------------------------------
// oldest_first_paired_fork_arbiter assertion macros
// shared concurrent assertion forms, clocked on clk, reset on rst
// ----------------------------------------------------------------------------
`ifndef OLDEST_FIRST_PAIRED_FORK_ARBITER_ASSERT_SVH
`define OLDEST_FIRST_PAIRED_FORK_ARBITER_ASSERT_SVH

// checked only outside reset
`define OFPFA_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define OFPFA_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/ofpfa_pkg.sv
// ----------------------------------------------------------------------------
// ofpfa_pkg
// types and constants shared by the paired fork arbiter modules
// ----------------------------------------------------------------------------
package ofpfa_pkg;

  localparam int NUM_REQUESTERS_DEF = 5;
  localparam int STAMP_BITS_DEF     = 32;

  localparam int REQ_BITS      = 3;
  localparam int STAMP_IN_BITS = 32;
  localparam int MASK_BITS     = 5;

  localparam logic FUNC_REQUEST = 1'b0;
  localparam logic FUNC_FINISH  = 1'b1;

  typedef struct packed {
    logic                     func;
    logic [REQ_BITS-1:0]      requester;
    logic [STAMP_IN_BITS-1:0] time_stamp;
  } in_item_t;

  typedef struct packed {
    logic [MASK_BITS-1:0] grant_mask;
    logic [MASK_BITS-1:0] free_mask;
    logic [MASK_BITS-1:0] holder_mask;
  } out_item_t;

  typedef struct packed {
    logic load;         // apply the accepted event
    logic release_hold; // drop pairs of requesters no longer asking
    logic start_visit;  // begin a search for the oldest waiting requester
    logic scan;         // compare one requester against the best so far
    logic commit;       // visit the chosen requester
    logic finish;       // capture the result word
  } cmd_t;

  typedef struct packed {
    logic pending;   // some waiting requester not yet visited
    logic scan_last; // scan stands on the last requester
  } status_t;

endpackage

>>> design/ofpfa_dpath.sv
// ----------------------------------------------------------------------------
// ofpfa_dpath
// request state, stamps, oldest-first search and pair allocation
// ----------------------------------------------------------------------------
module ofpfa_dpath
  import ofpfa_pkg::*;
#(
  parameter int NUM_REQUESTERS = NUM_REQUESTERS_DEF,
  parameter int STAMP_BITS     = STAMP_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  in_item_t  in_data,
  input  cmd_t      cmd,
  output status_t   status,
  output out_item_t out_data
);

  localparam int IW = (NUM_REQUESTERS > 1) ? $clog2(NUM_REQUESTERS) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(NUM_REQUESTERS - 1);

  function automatic logic [IW-1:0] next_seat(input logic [IW-1:0] i);
    return (i == LAST_IDX) ? '0 : i + IW'(1);
  endfunction

  logic [NUM_REQUESTERS-1:0] resource_free;
  logic [NUM_REQUESTERS-1:0] holding_pair;
  logic [NUM_REQUESTERS-1:0] wants_to_eat;
  logic [NUM_REQUESTERS-1:0] visited;
  logic [NUM_REQUESTERS-1:0] granted;
  logic [STAMP_BITS-1:0]     request_time [NUM_REQUESTERS];

  logic                  best_valid;
  logic [IW-1:0]         best_idx;
  logic [STAMP_BITS-1:0] best_time;
  logic [IW-1:0]         scan_idx;

  logic                              req_in_range;
  logic [IW-1:0]                     req_idx;
  logic [STAMP_BITS+STAMP_IN_BITS-1:0] stamp_wide;
  logic [STAMP_BITS-1:0]             stamp_in;

  logic [NUM_REQUESTERS-1:0] free_rel;
  logic [NUM_REQUESTERS-1:0] hold_rel;

  logic [STAMP_BITS-1:0]     cand_time;
  logic                      take;
  logic [IW-1:0]             own_idx;
  logic [IW-1:0]             nxt_idx;
  logic                      can_take;
  logic [NUM_REQUESTERS-1:0] pair_bits;

  logic [NUM_REQUESTERS+MASK_BITS-1:0] grant_pad;
  logic [NUM_REQUESTERS+MASK_BITS-1:0] free_pad;
  logic [NUM_REQUESTERS+MASK_BITS-1:0] hold_pad;

  logic pair_clash;

  // event decode, stamp kept in its low bits
  always_comb begin
    req_in_range = 32'(in_data.requester) < 32'(NUM_REQUESTERS);
    req_idx      = IW'(in_data.requester);
    stamp_wide   = {{STAMP_BITS{1'b0}}, in_data.time_stamp};
    stamp_in     = stamp_wide[STAMP_BITS-1:0];
  end

  // pairs held by requesters that stopped asking go back
  always_comb begin
    free_rel = resource_free;
    hold_rel = holding_pair;
    for (int i = 0; i < NUM_REQUESTERS; i++) begin
      if (!wants_to_eat[i] && holding_pair[i]) begin
        free_rel[i] = 1'b1;
        free_rel[(i == NUM_REQUESTERS - 1) ? 0 : i + 1] = 1'b1;
        hold_rel[i] = 1'b0;
      end
    end
  end

  // strict compare while scanning upward keeps ties on the lower index
  always_comb begin
    cand_time = request_time[scan_idx];
    take      = wants_to_eat[scan_idx] && !visited[scan_idx] &&
                (!best_valid || (cand_time < best_time));
    own_idx   = best_idx;
    nxt_idx   = next_seat(best_idx);
    can_take  = resource_free[own_idx] && resource_free[nxt_idx];
    pair_bits = '0;
    pair_bits[own_idx] = 1'b1;
    pair_bits[nxt_idx] = 1'b1;
  end

  assign status.pending   = |(wants_to_eat & ~visited);
  assign status.scan_last = (scan_idx == LAST_IDX);

  always_ff @(posedge clk) begin
    if (rst) begin
      resource_free <= '1;
      holding_pair  <= '0;
      wants_to_eat  <= '0;
      visited       <= '0;
      granted       <= '0;
      best_valid    <= 1'b0;
      scan_idx      <= '0;
    end else begin
      if (cmd.load && req_in_range) begin
        wants_to_eat[req_idx] <= (in_data.func == FUNC_REQUEST);
      end
      if (cmd.release_hold) begin
        resource_free <= free_rel;
        holding_pair  <= hold_rel;
        visited       <= '0;
        granted       <= '0;
      end
      if (cmd.start_visit) begin
        best_valid <= 1'b0;
        scan_idx   <= '0;
      end
      if (cmd.scan) begin
        if (take) begin
          best_valid <= 1'b1;
        end
        if (!status.scan_last) begin
          scan_idx <= scan_idx + IW'(1);
        end
      end
      if (cmd.commit) begin
        visited[own_idx] <= 1'b1;
        if (can_take) begin
          resource_free         <= resource_free & ~pair_bits;
          holding_pair[own_idx] <= 1'b1;
          granted[own_idx]      <= 1'b1;
        end
      end
    end
  end

  // stamps and search payload
  always_ff @(posedge clk) begin
    if (cmd.load && req_in_range && (in_data.func == FUNC_REQUEST)) begin
      request_time[req_idx] <= stamp_in;
    end
    if (cmd.scan && take) begin
      best_idx  <= scan_idx;
      best_time <= cand_time;
    end
  end

  // result word, masks cut or padded to the reported width
  always_comb begin
    grant_pad = {{MASK_BITS{1'b0}}, granted};
    free_pad  = {{MASK_BITS{1'b0}}, resource_free};
    hold_pad  = {{MASK_BITS{1'b0}}, holding_pair};
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_data.grant_mask  <= grant_pad[MASK_BITS-1:0];
      out_data.free_mask   <= free_pad[MASK_BITS-1:0];
      out_data.holder_mask <= hold_pad[MASK_BITS-1:0];
    end
  end

  // a holder owns both of its resources and no neighbor shares them
  always_comb begin
    pair_clash = 1'b0;
    for (int i = 0; i < NUM_REQUESTERS; i++) begin
      if (holding_pair[i] &&
          (resource_free[i] ||
           resource_free[(i == NUM_REQUESTERS - 1) ? 0 : i + 1] ||
           holding_pair[(i == NUM_REQUESTERS - 1) ? 0 : i + 1])) begin
        pair_clash = 1'b1;
      end
    end
  end

`include "oldest_first_paired_fork_arbiter_assert.svh"

  `OFPFA_ASSERT_ALWAYS(a_no_pair_clash, !pair_clash, "resource pair held twice or left free")
  `OFPFA_ASSERT(a_grant_is_holder, (granted & ~holding_pair) == '0, "grant without holding")
  `OFPFA_ASSERT(a_commit_marks_visit, cmd.commit |=> visited[$past(best_idx)], "visit not marked")

endmodule

>>> design/ofpfa_ctrl.sv
// ----------------------------------------------------------------------------
// ofpfa_ctrl
// sequencer for one arbitration round per event and the output handshake
// ----------------------------------------------------------------------------
module ofpfa_ctrl
  import ofpfa_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RELEASE,
    S_VISIT,
    S_SCAN,
    S_COMMIT,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_RELEASE;
        end
      end
      S_RELEASE: begin
        cmd.release_hold = 1'b1;
        state_next       = S_VISIT;
      end
      S_VISIT: begin
        if (status.pending) begin
          cmd.start_visit = 1'b1;
          state_next      = S_SCAN;
        end else begin
          state_next = S_DONE;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_last) begin
          state_next = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = S_VISIT;
      end
      S_DONE: begin
        // hold the round result until the output register is free
        if (out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`include "oldest_first_paired_fork_arbiter_assert.svh"

  `OFPFA_ASSERT(a_one_word_at_a_time, in_valid && in_ready |=> !in_ready, "second word taken mid round")
  `OFPFA_ASSERT(a_no_result_overwrite, cmd.finish |-> (!out_valid || out_ready), "result overwritten")

endmodule

>>> design/oldest_first_paired_fork_arbiter.sv
// ----------------------------------------------------------------------------
// oldest_first_paired_fork_arbiter
// ring of requesters sharing one resource between each pair of neighbors
// ----------------------------------------------------------------------------
// usage
// - in channel (in_valid/in_ready/in_data): one event word, a stamped request
//   or a finish for one requester; an out-of-range index changes nothing but
//   still yields a result
// - out channel (out_valid/out_ready/out_data): one result word per event
//   with the newly granted requesters, free resources and current holders
// - each event runs one round: held pairs of requesters no longer asking are
//   released, then waiting requesters are visited oldest stamp first (lower
//   index on a tie) and each takes its pair if both resources are free
// - search: the oldest-first search compares one stored stamp per cycle and
//   scans all NUM_REQUESTERS stamps for each waiting requester; a new event
//   is taken only once the round before it has handed its result to the
//   output register
// - the result sits in an output register: the next event is taken while it
//   waits; a stalled receiver only holds the following round at its end
// - reset (rst, synchronous): all resources free, no holders, no requests
// ----------------------------------------------------------------------------
module oldest_first_paired_fork_arbiter
  import ofpfa_pkg::*;
#(
  parameter int NUM_REQUESTERS = NUM_REQUESTERS_DEF,
  parameter int STAMP_BITS     = STAMP_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  cmd_t    cmd;
  status_t status;

  ofpfa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  ofpfa_dpath #(
    .NUM_REQUESTERS (NUM_REQUESTERS),
    .STAMP_BITS     (STAMP_BITS)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .in_data  (in_data),
    .cmd      (cmd),
    .status   (status),
    .out_data (out_data)
  );

endmodule

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// checks the paired fork arbiter against its own copy of the ring state: each
// accepted event updates the copy and queues the expected result word, and
// each result word leaving the block is compared with the oldest one queued.
// a directed opening is followed by random events under three idle mixes.
// ----------------------------------------------------------------------------
module testbench;
  import ofpfa_pkg::*;

  localparam int SEATS        = NUM_REQUESTERS_DEF;
  localparam int STALL_LIMIT  = 2000;
  localparam int ITEMS_PER_MIX = 333;
  localparam int TAIL_CYCLES  = 40;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  int send_idle = 24;
  int recv_idle = 71;
  int stuck_cycles = 0;
  int drains = 0;
  logic [STAMP_IN_BITS-1:0] clock_ms = '0;

  // keeps the ring state as the block should see it, plus the results still owed
  class ring_round_tracker;
    logic [SEATS-1:0]         fork_free;
    logic [SEATS-1:0]         holding;
    logic [SEATS-1:0]         wants;
    logic [STAMP_IN_BITS-1:0] stamps [SEATS];
    out_item_t                due_rounds [$];
    int errors, n_events, n_requests, n_finishes, n_off_ring, n_grants, peak_waiting;

    function new();
      fork_free = '1;
      holding   = '0;
      wants     = '0;
      foreach (stamps[i]) stamps[i] = '0;
      errors = 0; n_events = 0; n_requests = 0; n_finishes = 0;
      n_off_ring = 0; n_grants = 0; peak_waiting = 0;
    endfunction

    function int right_of(int i);
      return (i + 1 == SEATS) ? 0 : i + 1;
    endfunction

    // apply one event and run one arbitration round
    function out_item_t next_round(in_item_t ev);
      logic [SEATS-1:0] visited;
      logic [SEATS-1:0] granted;
      out_item_t        res;
      int               pick;
      int               r;
      visited = '0;
      granted = '0;
      if (ev.requester < SEATS) begin
        r = ev.requester;
        if (ev.func == FUNC_REQUEST) begin
          wants[r]  = 1'b1;
          stamps[r] = ev.time_stamp;
        end else begin
          wants[r] = 1'b0;
        end
      end
      for (int i = 0; i < SEATS; i++) begin
        if (!wants[i] && holding[i]) begin
          fork_free[i]           = 1'b1;
          fork_free[right_of(i)] = 1'b1;
          holding[i]             = 1'b0;
        end
      end
      // oldest stamp first, lower index wins a tie
      for (int n = 0; n < SEATS; n++) begin
        pick = -1;
        for (int i = 0; i < SEATS; i++) begin
          if (wants[i] && !visited[i] && (pick < 0 || stamps[i] < stamps[pick])) pick = i;
        end
        if (pick < 0) break;
        visited[pick] = 1'b1;
        if (fork_free[pick] && fork_free[right_of(pick)]) begin
          fork_free[pick]           = 1'b0;
          fork_free[right_of(pick)] = 1'b0;
          holding[pick]             = 1'b1;
          granted[pick]             = 1'b1;
        end
      end
      res.grant_mask  = granted;
      res.free_mask   = fork_free;
      res.holder_mask = holding;
      return res;
    endfunction

    function void note_event(in_item_t ev);
      out_item_t res;
      int        waiting;
      n_events++;
      if (ev.requester >= SEATS) n_off_ring++;
      else if (ev.func == FUNC_REQUEST) n_requests++;
      else n_finishes++;
      res = next_round(ev);
      n_grants += $countones(res.grant_mask);
      waiting = $countones(wants & ~holding);
      if (waiting > peak_waiting) peak_waiting = waiting;
      due_rounds.push_back(res);
    endfunction

    function void check_round(out_item_t got);
      out_item_t want;
      if (due_rounds.size() == 0) begin
        $error("result word %h arrived with nothing outstanding", got);
        errors++;
        return;
      end
      want = due_rounds.pop_front();
      if (got.grant_mask !== want.grant_mask) begin
        $error("grant_mask: expected %b, got %b", want.grant_mask, got.grant_mask);
        errors++;
      end
      if (got.free_mask !== want.free_mask) begin
        $error("free_mask: expected %b, got %b", want.free_mask, got.free_mask);
        errors++;
      end
      if (got.holder_mask !== want.holder_mask) begin
        $error("holder_mask: expected %b, got %b", want.holder_mask, got.holder_mask);
        errors++;
      end
    endfunction
  endclass

  ring_round_tracker tracker = new();

  oldest_first_paired_fork_arbiter i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #4 clk = ~clk;

  always @(negedge clk) begin
    out_ready = ($urandom_range(0, 99) >= recv_idle);
  end

  // handshake monitor and stall watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) tracker.note_event(in_data);
      if (out_valid && out_ready) tracker.check_round(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
      end
      if (stuck_cycles >= STALL_LIMIT) begin
        $display("no handshake for %0d cycles", STALL_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic send_event(input in_item_t ev);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_data  = ev;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_fields(input logic func, input int who, input logic [31:0] stamp);
    in_item_t ev;
    ev.func       = func;
    ev.requester  = who[REQ_BITS-1:0];
    ev.time_stamp = stamp;
    send_event(ev);
  endtask

  // hold the sender off until every owed result word is back
  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (tracker.due_rounds.size() != 0) @(posedge clk);
    drains++;
  endtask

  function automatic logic [STAMP_IN_BITS-1:0] pick_stamp();
    case ($urandom_range(0, 5))
      0, 1: return $urandom;
      2:    return $urandom_range(0, 7);
      3:    return $urandom_range(0, 1) ? '0 : '1;
      default: begin
        clock_ms += $urandom_range(0, 50);
        return clock_ms;
      end
    endcase
  endfunction

  task automatic send_random_event();
    in_item_t ev;
    int       who;
    int       finish_pct;
    if ($urandom_range(0, 99) < 5) begin
      who = $urandom_range(SEATS, 7);
      finish_pct = 50;
    end else begin
      who = $urandom_range(0, SEATS - 1);
      // holders tend to finish, waiters mostly keep asking
      if (tracker.holding[who]) finish_pct = 60;
      else if (tracker.wants[who]) finish_pct = 25;
      else finish_pct = 8;
    end
    ev.func       = ($urandom_range(0, 99) < finish_pct) ? FUNC_FINISH : FUNC_REQUEST;
    ev.requester  = who[REQ_BITS-1:0];
    ev.time_stamp = pick_stamp();
    send_event(ev);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // seat 0 eats, its neighbors queue up behind it
    send_fields(FUNC_REQUEST, 0, 32'h0000_0000);
    send_fields(FUNC_REQUEST, 1, 32'h0000_0005);
    send_fields(FUNC_REQUEST, 4, 32'hFFFF_FFFF);
    // release of seat 0 lets both neighbors in
    send_fields(FUNC_FINISH,  0, 32'h1234_5678);
    send_fields(FUNC_REQUEST, 2, 32'h0000_0003);
    send_fields(FUNC_REQUEST, 3, 32'h0000_0003);
    send_fields(FUNC_FINISH,  1, 32'h0000_0000);
    // repeated request by a holder keeps the pair
    send_fields(FUNC_REQUEST, 2, 32'h0000_0007);
    // withdraw a waiter, then finish with nothing pending
    send_fields(FUNC_FINISH,  3, 32'hAAAA_AAAA);
    send_fields(FUNC_FINISH,  3, 32'h5555_5555);
    // off-ring indexes change nothing
    send_fields(FUNC_REQUEST, 5, 32'h0000_0001);
    send_fields(FUNC_REQUEST, 6, 32'hFFFF_FFFF);
    send_fields(FUNC_REQUEST, 7, 32'h8000_0000);
    send_fields(FUNC_FINISH,  7, 32'h7FFF_FFFF);
    send_fields(FUNC_FINISH,  2, 32'h0000_0000);
    send_fields(FUNC_FINISH,  4, 32'h0000_0000);
    // equal stamps on every seat
    send_fields(FUNC_REQUEST, 1, 32'h0000_0042);
    send_fields(FUNC_REQUEST, 0, 32'h0000_0042);
    send_fields(FUNC_REQUEST, 2, 32'h0000_0042);
    send_fields(FUNC_REQUEST, 3, 32'h0000_0042);
    send_fields(FUNC_REQUEST, 4, 32'h0000_0042);
    send_fields(FUNC_FINISH,  1, 32'h0000_0042);
    send_fields(FUNC_FINISH,  3, 32'h0000_0042);

    for (int mix = 0; mix < 3; mix++) begin
      drain_results();
      case (mix)
        0: begin send_idle = 24; recv_idle = 71; end
        1: begin send_idle = 71; recv_idle = 24; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      for (int k = 0; k < ITEMS_PER_MIX; k++) begin
        if ($urandom_range(0, 99) == 0) drain_results();
        send_random_event();
      end
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (tracker.due_rounds.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d events: %0d requests, %0d finishes, %0d off-ring; %0d pairs granted",
             tracker.n_events, tracker.n_requests, tracker.n_finishes, tracker.n_off_ring,
             tracker.n_grants);
    $display("up to %0d seats waiting at once; %0d full drains across three idle mixes",
             tracker.peak_waiting, drains);
    if (tracker.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
